// ===== rtl/lpbr_pkg.sv =====
// Shared types and constants of the length-prefixed byte ring.
package lpbr_pkg;

	localparam int CAPACITY_DEF = 8192;
	localparam int HDR_BYTES    = 4;
	localparam int FUNC_W       = 2;
	localparam int LEN_W        = 13;
	localparam int BYTE_W       = 8;
	localparam int STATUS_W     = 3;
	localparam int IN_TDATA_W   = 24;
	localparam logic [1:0] HDR_LAST = 2'(HDR_BYTES - 1);

	typedef enum logic [FUNC_W-1:0] {
		FN_PUSH_BEGIN = 2'd0,
		FN_PUSH_BYTE  = 2'd1,
		FN_POP        = 2'd2
	} func_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 3'd0,
		ST_ZERO_LEN  = 3'd1,
		ST_EMPTY     = 3'd2,
		ST_TOO_LARGE = 3'd3,
		ST_NO_SPACE  = 3'd4,
		ST_NO_PUSH   = 3'd5,
		ST_PUSH_OPEN = 3'd6
	} status_t;

	typedef struct packed {
		status_t            status;
		logic [BYTE_W-1:0]  read_byte;
		logic               last;
	} result_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic       hdr_start;
		logic       hdr_step;
		logic [1:0] phase;
		logic       push_byte;
		logic       pop_start;
		logic       hdr_rd_step;
		logic       pop_zero;
		logic       pop_open_start;
		logic       data_rd;
		logic       data_done;
		logic       post;
		status_t    post_status;
		logic       post_data;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic push_open;
		logic pop_open;
		logic too_large;
		logic no_space;
		logic empty;
		logic size_zero;
	} dp_sts_t;

endpackage

// ===== rtl/lpbr_ram.sv =====
// Generic single-port RAM with registered read data.
module lpbr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8192
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end

endmodule

// ===== rtl/lpbr_ctrl.sv =====
// Controller state machine: sequences header writes, header reads and byte reads.
module lpbr_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	input  logic [lpbr_pkg::FUNC_W-1:0]   func,
	input  logic                          can_post,
	input  lpbr_pkg::dp_sts_t             sts,
	output logic                          s_tready,
	output lpbr_pkg::cmd_t                cmd
);

	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_HDR_WR = 4'b0010,
		S_HDR_RD = 4'b0100,
		S_DATA   = 4'b1000
	} state_t;

	state_t     state_q, state_d;
	logic [1:0] ph_q, ph_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ph_q    <= '0;
		end else begin
			state_q <= state_d;
			ph_q    <= ph_d;
		end
	end

	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		ph_d     = ph_q;
		s_tready = 1'b0;
		cmd.phase = ph_q;
		unique case (state_q)
			S_IDLE: begin
				s_tready = can_post;
				if (s_tvalid && can_post) begin
					unique case (lpbr_pkg::func_t'(func))
						lpbr_pkg::FN_PUSH_BEGIN: begin
							cmd.post = 1'b1;
							if (sts.push_open) begin
								cmd.post_status = lpbr_pkg::ST_PUSH_OPEN;
							end else if (sts.too_large) begin
								cmd.post_status = lpbr_pkg::ST_TOO_LARGE;
							end else if (sts.no_space) begin
								cmd.post_status = lpbr_pkg::ST_NO_SPACE;
							end else begin
								cmd.post_status = lpbr_pkg::ST_OK;
								cmd.hdr_start   = 1'b1;
								ph_d            = 2'd1;
								state_d         = S_HDR_WR;
							end
						end
						lpbr_pkg::FN_PUSH_BYTE: begin
							cmd.post = 1'b1;
							if (sts.push_open) begin
								cmd.post_status = lpbr_pkg::ST_OK;
								cmd.push_byte   = 1'b1;
							end else begin
								cmd.post_status = lpbr_pkg::ST_NO_PUSH;
							end
						end
						lpbr_pkg::FN_POP: begin
							if (sts.pop_open) begin
								cmd.data_rd = 1'b1;
								state_d     = S_DATA;
							end else if (sts.empty) begin
								cmd.post        = 1'b1;
								cmd.post_status = lpbr_pkg::ST_EMPTY;
							end else begin
								cmd.pop_start = 1'b1;
								ph_d          = 2'd0;
								state_d       = S_HDR_RD;
							end
						end
						default: begin
							cmd.post        = 1'b1;
							cmd.post_status = lpbr_pkg::ST_OK;
						end
					endcase
				end
			end
			S_HDR_WR: begin
				cmd.hdr_step = 1'b1;
				ph_d         = ph_q + 2'd1;
				if (ph_q == lpbr_pkg::HDR_LAST) begin
					state_d = S_IDLE;
				end
			end
			S_HDR_RD: begin
				if (ph_q != lpbr_pkg::HDR_LAST) begin
					cmd.hdr_rd_step = 1'b1;
					ph_d            = ph_q + 2'd1;
				end else if (!sts.size_zero) begin
					cmd.pop_open_start = 1'b1;
					cmd.data_rd        = 1'b1;
					state_d            = S_DATA;
				end else if (can_post) begin
					// An empty message is consumed whole by this beat.
					cmd.pop_zero    = 1'b1;
					cmd.post        = 1'b1;
					cmd.post_status = lpbr_pkg::ST_ZERO_LEN;
					state_d         = S_IDLE;
				end
			end
			S_DATA: begin
				if (can_post) begin
					cmd.data_done   = 1'b1;
					cmd.post        = 1'b1;
					cmd.post_status = lpbr_pkg::ST_OK;
					cmd.post_data   = 1'b1;
					state_d         = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

// ===== rtl/lpbr_obuf.sv =====
// Two-entry result buffer in front of the master-side stream port.
module lpbr_obuf (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              post,
	input  lpbr_pkg::result_t res,
	input  logic              m_tready,
	output logic              m_tvalid,
	output lpbr_pkg::result_t out,
	output logic              can_post
);

	logic              out_v_q, pend_v_q;
	lpbr_pkg::result_t out_q, pend_q;
	logic              out_free;

	assign out_free = !out_v_q || m_tready;
	assign can_post = !pend_v_q || out_free;
	assign m_tvalid = out_v_q;
	assign out      = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			pend_v_q <= 1'b0;
		end else if (out_free) begin
			out_v_q  <= pend_v_q || post;
			pend_v_q <= pend_v_q && post;
		end else if (post) begin
			pend_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (pend_v_q) begin
				out_q <= pend_q;
				if (post) begin
					pend_q <= res;
				end
			end else if (post) begin
				out_q <= res;
			end
		end else if (post) begin
			pend_q <= res;
		end
	end

endmodule

// ===== rtl/lpbr_dp.sv =====
// Datapath: ring pointers, message counters, space checks and the byte store.
module lpbr_dp #(
	parameter int CAPACITY = lpbr_pkg::CAPACITY_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  lpbr_pkg::cmd_t              cmd,
	input  logic [lpbr_pkg::LEN_W-1:0]  message_length,
	input  logic [lpbr_pkg::BYTE_W-1:0] data_byte,
	output lpbr_pkg::dp_sts_t           sts,
	output lpbr_pkg::result_t           res
);

	localparam int PTR_W = $clog2(CAPACITY);
	localparam int CAP_W = $clog2(CAPACITY + 1);
	localparam int CNT_W = (CAP_W > lpbr_pkg::LEN_W + 1) ? CAP_W : lpbr_pkg::LEN_W + 1;
	localparam int LEN_W = lpbr_pkg::LEN_W;
	localparam int BYTE_W = lpbr_pkg::BYTE_W;

	function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
		ring_next = (p == PTR_W'(CAPACITY - 1)) ? '0 : p + 1'b1;
	endfunction

	logic [PTR_W-1:0]  head_q, tail_q, wi_q, ri_q;
	logic [LEN_W-1:0]  push_rem_q, pop_rem_q, len_q, size_q;
	logic              push_open_q, pop_open_q;
	logic [BYTE_W-1:0] b0_q;

	logic              ram_en, ram_we;
	logic [PTR_W-1:0]  ram_addr;
	logic [BYTE_W-1:0] ram_wdata, ram_rdata;
	logic [CNT_W-1:0]  total, room;

	assign total = CNT_W'(lpbr_pkg::HDR_BYTES) + CNT_W'(message_length);
	assign room = (tail_q <= head_q)
		? CNT_W'(CAPACITY) - CNT_W'(head_q) + CNT_W'(tail_q)
		: CNT_W'(tail_q) - CNT_W'(head_q);

	assign sts.push_open = push_open_q;
	assign sts.pop_open  = pop_open_q;
	assign sts.too_large = total > CNT_W'(CAPACITY);
	// One byte always stays free, so equal space is not enough.
	assign sts.no_space  = room <= total;
	assign sts.empty     = head_q == tail_q;
	assign sts.size_zero = size_q == '0;

	assign res.status    = cmd.post_status;
	assign res.read_byte = cmd.post_data ? ram_rdata : '0;
	assign res.last      = (cmd.post_status == lpbr_pkg::ST_ZERO_LEN)
		|| (cmd.post_data && pop_rem_q <= LEN_W'(1));

	always_comb begin
		ram_en    = 1'b0;
		ram_we    = 1'b0;
		ram_addr  = ri_q;
		ram_wdata = '0;
		priority if (cmd.hdr_start) begin
			ram_en    = 1'b1;
			ram_we    = 1'b1;
			ram_addr  = head_q;
			ram_wdata = message_length[BYTE_W-1:0];
		end else if (cmd.hdr_step) begin
			ram_en    = 1'b1;
			ram_we    = 1'b1;
			ram_addr  = wi_q;
			ram_wdata = (cmd.phase == 2'd1) ? BYTE_W'(len_q >> BYTE_W) : '0;
		end else if (cmd.push_byte) begin
			ram_en    = 1'b1;
			ram_we    = 1'b1;
			ram_addr  = wi_q;
			ram_wdata = data_byte;
		end else if (cmd.pop_start) begin
			ram_en   = 1'b1;
			ram_addr = tail_q;
		end else if (cmd.hdr_rd_step || cmd.data_rd) begin
			ram_en   = 1'b1;
			ram_addr = ri_q;
		end else begin
			ram_en = 1'b0;
		end
	end

	lpbr_ram #(
		.WIDTH(BYTE_W),
		.DEPTH(CAPACITY)
	) u_store (
		.clk  (clk),
		.en   (ram_en),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			tail_q      <= '0;
			wi_q        <= '0;
			ri_q        <= '0;
			push_rem_q  <= '0;
			pop_rem_q   <= '0;
			push_open_q <= 1'b0;
			pop_open_q  <= 1'b0;
			len_q       <= '0;
			size_q      <= '0;
			b0_q        <= '0;
		end else begin
			if (cmd.hdr_start) begin
				len_q <= message_length;
				wi_q  <= ring_next(head_q);
			end
			if (cmd.hdr_step) begin
				wi_q <= ring_next(wi_q);
				if (cmd.phase == lpbr_pkg::HDR_LAST) begin
					if (len_q == '0) begin
						head_q <= ring_next(wi_q);
					end else begin
						push_open_q <= 1'b1;
						push_rem_q  <= len_q;
					end
				end
			end
			if (cmd.push_byte) begin
				wi_q       <= ring_next(wi_q);
				push_rem_q <= push_rem_q - LEN_W'(1);
				if (push_rem_q <= LEN_W'(1)) begin
					head_q      <= ring_next(wi_q);
					push_open_q <= 1'b0;
				end
			end
			if (cmd.pop_start) begin
				ri_q <= ring_next(tail_q);
			end
			if (cmd.hdr_rd_step) begin
				ri_q <= ring_next(ri_q);
				if (cmd.phase == 2'd0) begin
					b0_q <= ram_rdata;
				end
				if (cmd.phase == 2'd1) begin
					size_q <= {ram_rdata[LEN_W-BYTE_W-1:0], b0_q};
				end
			end
			if (cmd.pop_zero) begin
				tail_q <= ri_q;
			end
			if (cmd.pop_open_start) begin
				pop_open_q <= 1'b1;
				pop_rem_q  <= size_q;
			end
			if (cmd.data_done) begin
				ri_q      <= ring_next(ri_q);
				pop_rem_q <= pop_rem_q - LEN_W'(1);
				if (pop_rem_q <= LEN_W'(1)) begin
					tail_q     <= ring_next(ri_q);
					pop_open_q <= 1'b0;
				end
			end
		end
	end

endmodule

// ===== rtl/length_prefixed_byte_ring.sv =====
// Push data byte, error results, empty pop: the result is posted on accept; no wait state.
// Push begin: result posted on accept, then S_HDR_WR writes the rest of the header.
// Pop of a byte inside an open message: one read of the single-port store, posted in S_DATA.
// First pop: header read in S_HDR_RD, then the data read; a zero-length message ends there.
// Reset clears all pointers and flags at once; the byte store is not cleared.
// Top level of the length-prefixed byte ring.
module length_prefixed_byte_ring #(
	parameter int CAPACITY = lpbr_pkg::CAPACITY_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// [12:0] message_length, [20:13] data_byte, [23:21] zero
	input  logic [lpbr_pkg::IN_TDATA_W-1:0] s_tdata,
	// [1:0] func
	input  logic [lpbr_pkg::FUNC_W-1:0]     s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// [7:0] read_byte
	output logic [lpbr_pkg::BYTE_W-1:0]     m_tdata,
	// [2:0] status
	output logic [lpbr_pkg::STATUS_W-1:0]   m_tuser,
	output logic                            m_tlast
);

	lpbr_pkg::cmd_t    cmd;
	lpbr_pkg::dp_sts_t sts;
	lpbr_pkg::result_t res, out;
	logic              can_post;

	lpbr_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.func    (s_tuser),
		.can_post(can_post),
		.sts     (sts),
		.s_tready(s_tready),
		.cmd     (cmd)
	);

	lpbr_dp #(
		.CAPACITY(CAPACITY)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.message_length(s_tdata[lpbr_pkg::LEN_W-1:0]),
		.data_byte     (s_tdata[lpbr_pkg::LEN_W +: lpbr_pkg::BYTE_W]),
		.sts           (sts),
		.res           (res)
	);

	lpbr_obuf u_obuf (
		.clk     (clk),
		.arst_n  (arst_n),
		.post    (cmd.post),
		.res     (res),
		.m_tready(m_tready),
		.m_tvalid(m_tvalid),
		.out     (out),
		.can_post(can_post)
	);

	assign m_tdata = out.read_byte;
	assign m_tuser = out.status;
	assign m_tlast = out.last;

	a_last_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |->
			(m_tuser == lpbr_pkg::ST_OK || m_tuser == lpbr_pkg::ST_ZERO_LEN))
		else $error("last mark on a beat that carries no popped byte");

	a_byte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != lpbr_pkg::ST_OK |-> m_tdata == '0)
		else $error("data byte set on a beat with a non-ok status");

	a_zero_len_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == lpbr_pkg::ST_ZERO_LEN |-> m_tlast)
		else $error("empty message popped without a last mark");

endmodule
